// File: design/appm_pkg.sv
package appm_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_OVERFLOW = 3'd1,
    OP_CAPTURE  = 3'd2,
    OP_EDGE     = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STATUS_PERIOD   = 2'd0,
    STATUS_SLOW     = 2'd1,
    STATUS_NO_PULSE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_SINGLE_ENTER = 3'd0,
    REG_SINGLE_LEAVE = 3'd1,
    REG_SPARSE_EXIT  = 3'd2,
    REG_FAST_TIMEOUT = 3'd3,
    REG_SLOW_TIMEOUT = 3'd4,
    REG_NO_PULSE     = 3'd5,
    REG_HALF_INIT    = 3'd6
  } reg_e;

  typedef struct packed {
    logic [7:0] single_enter_below;
    logic [7:0] single_leave_above;
    logic [8:0] sparse_exit_sum;
    logic [7:0] fast_timeout;
    logic [7:0] slow_timeout;
    logic [7:0] no_pulse_ticks;
    logic [7:0] half_init;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [23:0] period;
    logic        sparse_active;
    logic        single_shot;
  } result_t;

  localparam logic [7:0]  RstSingleEnter = 8'd12;
  localparam logic [7:0]  RstSingleLeave = 8'd24;
  localparam logic [8:0]  RstSparseExit  = 9'd38;
  localparam logic [7:0]  RstFastTimeout = 8'd82;
  localparam logic [7:0]  RstSlowTimeout = 8'd162;
  localparam logic [7:0]  RstNoPulse     = 8'd168;
  localparam logic [7:0]  RstHalfInit    = 8'd45;
  localparam logic [7:0]  RstTickCount   = 8'd200;
  localparam logic [23:0] AllOnes24      = 24'hFF_FFFF;

endpackage

// File: design/appm_cfg.sv
module appm_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [appm_pkg::AddrW-1:0] paddr,
  input  logic [appm_pkg::DataW-1:0] pwdata,
  output logic [appm_pkg::DataW-1:0] prdata,
  output appm_pkg::cfg_t             cfg_o
);
  import appm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;
  reg_e idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_e'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SINGLE_ENTER: cfg_d.single_enter_below = pwdata[7:0];
        REG_SINGLE_LEAVE: cfg_d.single_leave_above = pwdata[7:0];
        REG_SPARSE_EXIT:  cfg_d.sparse_exit_sum    = pwdata[8:0];
        REG_FAST_TIMEOUT: cfg_d.fast_timeout       = pwdata[7:0];
        REG_SLOW_TIMEOUT: cfg_d.slow_timeout       = pwdata[7:0];
        REG_NO_PULSE:     cfg_d.no_pulse_ticks     = pwdata[7:0];
        REG_HALF_INIT:    cfg_d.half_init          = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SINGLE_ENTER: prdata = {24'd0, cfg_q.single_enter_below};
      REG_SINGLE_LEAVE: prdata = {24'd0, cfg_q.single_leave_above};
      REG_SPARSE_EXIT:  prdata = {23'd0, cfg_q.sparse_exit_sum};
      REG_FAST_TIMEOUT: prdata = {24'd0, cfg_q.fast_timeout};
      REG_SLOW_TIMEOUT: prdata = {24'd0, cfg_q.slow_timeout};
      REG_NO_PULSE:     prdata = {24'd0, cfg_q.no_pulse_ticks};
      REG_HALF_INIT:    prdata = {24'd0, cfg_q.half_init};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.single_enter_below <= RstSingleEnter;
      cfg_q.single_leave_above <= RstSingleLeave;
      cfg_q.sparse_exit_sum    <= RstSparseExit;
      cfg_q.fast_timeout       <= RstFastTimeout;
      cfg_q.slow_timeout       <= RstSlowTimeout;
      cfg_q.no_pulse_ticks     <= RstNoPulse;
      cfg_q.half_init          <= RstHalfInit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/appm_engine.sv
module appm_engine #(
  parameter int unsigned TICKS_PER_SLOT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [2:0]        op_i,
  input  logic [15:0]       count_low_i,
  input  appm_pkg::cfg_t    cfg_i,
  output appm_pkg::result_t result_o
);
  import appm_pkg::*;

  localparam logic [2:0] SlotCount = 3'(TICKS_PER_SLOT);
  localparam logic [1:0] SlotLast  = 2'(TICKS_PER_SLOT - 1);

  logic        sparse_q, sparse_d;
  logic        first_q, first_d;
  logic [7:0]  tick_q, tick_d;
  logic [7:0]  half_a_q, half_a_d;
  logic [7:0]  half_b_q, half_b_d;
  logic        phase_q, phase_d;
  logic [7:0]  ovf_q, ovf_d;
  logic [23:0] last_q, last_d;
  logic        single_q, single_d;
  logic        armed_q, armed_d;
  logic        comp_q, comp_d;
  logic [1:0]  slot_q, slot_d;

  logic [7:0]  tick_inc;
  logic [8:0]  half_sum;
  logic [2:0]  slot_next;

  assign tick_inc = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
  assign half_sum = {1'b0, half_a_q} + {1'b0, half_b_q};

  always_comb begin
    sparse_d  = sparse_q;
    first_d   = first_q;
    tick_d    = tick_q;
    half_a_d  = half_a_q;
    half_b_d  = half_b_q;
    phase_d   = phase_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    single_d  = single_q;
    armed_d   = armed_q;
    comp_d    = comp_q;
    slot_d    = slot_q;
    slot_next = '0;
    if (step_i) begin
      case (op_e'(op_i))
        OP_TICK: begin
          tick_d = tick_inc;
          if (sparse_q && (half_sum < cfg_i.sparse_exit_sum)) begin
            comp_d   = 1'b0;
            single_d = 1'b1;
            ovf_d    = '0;
            tick_d   = '0;
            last_d   = AllOnes24;
            sparse_d = 1'b0;
            first_d  = 1'b1;
            slot_d   = SlotLast;
          end else if (!sparse_q && (((tick_inc > cfg_i.fast_timeout) && !first_q) ||
                                     (tick_inc > cfg_i.slow_timeout))) begin
            tick_d   = '0;
            half_a_d = cfg_i.half_init;
            half_b_d = cfg_i.half_init;
            sparse_d = 1'b1;
            first_d  = 1'b1;
            slot_d   = SlotLast;
          end
          slot_next = {1'b0, slot_d} + 3'd1;
          if (slot_next < SlotCount) begin
            slot_d = slot_next[1:0];
          end else begin
            slot_d = '0;
            if (!sparse_d) begin
              if (single_d) armed_d = 1'b1;
            end else begin
              comp_d = 1'b1;
            end
          end
        end
        OP_OVERFLOW: begin
          if (!sparse_q && (ovf_q != 8'hFF)) ovf_d = ovf_q + 8'd1;
        end
        OP_CAPTURE: begin
          if (!sparse_q && !(single_q && !armed_q)) begin
            last_d = {ovf_q, count_low_i};
            if (ovf_q < cfg_i.single_enter_below) begin
              single_d = 1'b1;
            end else if (ovf_q > cfg_i.single_leave_above) begin
              single_d = 1'b0;
            end
            armed_d = 1'b0;
            ovf_d   = '0;
            tick_d  = '0;
            first_d = 1'b0;
          end
        end
        OP_EDGE: begin
          if (sparse_q && comp_q) begin
            first_d = 1'b0;
            phase_d = !phase_q;
            if (phase_q) half_a_d = tick_q;
            else         half_b_d = tick_q;
            tick_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.sparse_active = sparse_d;
    result_o.single_shot   = single_d;
    if (sparse_d) begin
      result_o.status = (tick_d >= cfg_i.no_pulse_ticks) ? STATUS_NO_PULSE : STATUS_SLOW;
      result_o.period = AllOnes24;
    end else begin
      result_o.status = STATUS_PERIOD;
      result_o.period = (last_d[23:16] == 8'hFF) ? AllOnes24 : last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sparse_q <= 1'b0;
      first_q  <= 1'b0;
      tick_q   <= RstTickCount;
      half_a_q <= '0;
      half_b_q <= '0;
      phase_q  <= 1'b0;
      ovf_q    <= '0;
      last_q   <= AllOnes24;
      single_q <= 1'b0;
      armed_q  <= 1'b0;
      comp_q   <= 1'b0;
      slot_q   <= '0;
    end else begin
      sparse_q <= sparse_d;
      first_q  <= first_d;
      tick_q   <= tick_d;
      half_a_q <= half_a_d;
      half_b_q <= half_b_d;
      phase_q  <= phase_d;
      ovf_q    <= ovf_d;
      last_q   <= last_d;
      single_q <= single_d;
      armed_q  <= armed_d;
      comp_q   <= comp_d;
      slot_q   <= slot_d;
    end
  end

endmodule

// File: design/autoranging_pulse_period_meter_core.sv
// Channel | Direction | tdata (low bit up)                            | tuser
// s_axis  | in        | count_low[15:0]                               | op[2:0]
// m_axis  | out       | period[23:0], sparse_active, single_shot, pad | status[1:0]
// apb     | in        | registers at byte address 4*i, i = 0..6       | -
//
// An accepted transaction is held in the input register until the output can take it; its
// state update and result are then formed combinationally and written to the output register.
// The result reaches m_axis through the input and output registers, and one transaction is taken
// every cycle while m_axis is not stalled.
// Reset restores the register defaults and the state after power-up; no clearing pass.
// A stalled output holds the input register, which then lowers s_axis_tready.
module autoranging_pulse_period_meter_core #(
  parameter int unsigned TICKS_PER_SLOT = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // count_low
  input  logic [2:0]                 s_axis_tuser,  // op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // period, sparse_active, single_shot
  output logic [1:0]                 m_axis_tuser,  // status
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [appm_pkg::AddrW-1:0] paddr,
  input  logic [appm_pkg::DataW-1:0] pwdata,
  output logic [appm_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import appm_pkg::*;

  cfg_t        cfg;
  result_t     result;
  logic        in_valid_q;
  logic [2:0]  in_op_q;
  logic [15:0] in_low_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        advance;

  assign pready        = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  appm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  appm_engine #(
    .TICKS_PER_SLOT (TICKS_PER_SLOT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .op_i        (in_op_q),
    .count_low_i (in_low_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= s_axis_tuser;
      in_low_q <= s_axis_tdata;
    end
    if (advance) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.single_shot, out_q.sparse_active, out_q.period};
  assign m_axis_tuser  = out_q.status;

endmodule
